// ----- hdl/bms_pkg.sv -----
// Shared types, codes and constants of the bilinear mask sampler.
`default_nettype none

package bms_pkg;

    // Operand and product widths of the shared multiply-add unit
    localparam int MAC_A_W = 26;
    localparam int MAC_B_W = 18;
    localparam int MAC_P_W = 44;

    // Operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Channel that resets to full scale, and its reset byte
    localparam int         ALPHA_CH    = 3;
    localparam logic [7:0] ALPHA_RESET = 8'hFF;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [7:0]  WR_SCALE   = 8'd255;
    localparam logic [15:0] ROUND_HALF = 16'h8000;
    localparam logic [8:0]  SIDE_RESET = 9'd256;

    // One request to the multiply-add unit: p = a * b + c
    typedef struct packed {
        logic                        en;
        logic signed [MAC_A_W-1:0]   a;
        logic signed [MAC_B_W-1:0]   b;
        logic signed [MAC_P_W-1:0]   c;
    } t_mac_op;

    // Clamp a signed Q1.16 value to 0..1
    function automatic logic [16:0] clamp_unit(input logic signed [17:0] v);
        logic [16:0] res;
        if (v < 18'sd0) begin
            res = 17'd0;
        end else if (v > 18'sd65536) begin
            res = ONE_Q16;
        end else begin
            res = v[16:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bms_mac.sv -----
// Shared signed multiply-add unit with a registered product.
`default_nettype none

module bms_mac
    import bms_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire t_mac_op                   i_op,
    output logic signed [MAC_P_W-1:0]      o_p
);

    logic signed [MAC_P_W-1:0] r_p;

    // Compute a * b + c when requested, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_p <= i_op.a * i_op.b + i_op.c;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ----- hdl/bms_store.sv -----
// Single-port texel store, one byte lane per channel, registered read.
`default_nettype none

module bms_store #(
    parameter int DEPTH = 65536,
    parameter int LANES = 4
) (
    input  wire logic                        i_clk,
    input  wire logic [LANES-1:0]            i_we,
    input  wire logic [$clog2(DEPTH)-1:0]    i_addr,
    input  wire logic [LANES-1:0][7:0]       i_wdata,
    output logic [LANES-1:0][7:0]            o_rdata
);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [7:0] r_mem [DEPTH];
        logic [7:0] r_rd;

        // Write the lane when enabled, read every cycle
        always_ff @(posedge i_clk) begin
            if (i_we[g]) begin
                r_mem[i_addr] <= i_wdata[g];
            end
            r_rd <= r_mem[i_addr];
        end

        assign o_rdata[g] = r_rd;
    end

endmodule

`default_nettype wire

// ----- hdl/bilinear_mask_sampler.sv -----
// Top level of the bilinear mask sampler: sequencer, config and result register.
// An RGBA8 mask texture in a single-port store of MAX_SIDE*MAX_SIDE texels,
// addressed row by row with the current width. After reset the block clears
// the store, one texel per cycle, with o_ready low; configuration writes are
// taken meanwhile. One item is worked at a time under a small sequencer that
// drives one shared multiply-add unit and the store port. A write passes the
// states ADDR, WV and WR, a read ADDR, RD and RDW, and a bilinear sample PU
// to RES (two coordinate scalings, two row products, four texel reads and
// three lerp steps all go through the same multiplier and store port); each
// then loads its result into the output register from DONE, where an item
// that is rejected or out of range goes straight. The input is ready again
// only once that result is loaded, so a new item is never taken before the
// last is finished. A finished result waits in the output register while the
// next item is taken; a second result waits in the sequencer until the first
// is transferred.
`default_nettype none

module bilinear_mask_sampler
    import bms_pkg::*;
#(
    parameter int MAX_SIDE = 256,
    parameter int CHANNELS = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input item channel
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [7:0]          i_texel_x,
    input  wire logic [7:0]          i_texel_z,
    input  wire logic [1:0]          i_channel_sel,
    input  wire logic signed [17:0]  i_write_value,
    input  wire logic signed [17:0]  i_coord_u,
    input  wire logic signed [17:0]  i_coord_v,
    // Result channel
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [15:0]              o_result_value,
    // Configuration write port
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [8:0]          i_cfg_wdata
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_CLEAR = 20'h00002,
        ST_ADDR  = 20'h00004,
        ST_WV    = 20'h00008,
        ST_WR    = 20'h00010,
        ST_RD    = 20'h00020,
        ST_RDW   = 20'h00040,
        ST_PU    = 20'h00080,
        ST_PV    = 20'h00100,
        ST_ZA    = 20'h00200,
        ST_ZB    = 20'h00400,
        ST_R00   = 20'h00800,
        ST_R10   = 20'h01000,
        ST_R01   = 20'h02000,
        ST_R11   = 20'h04000,
        ST_TOP   = 20'h08000,
        ST_BOT   = 20'h10000,
        ST_FULL  = 20'h20000,
        ST_RES   = 20'h40000,
        ST_DONE  = 20'h80000
    } t_state;

    t_state                    r_state, n_state;
    logic [AW-1:0]             r_clr_addr;
    logic [8:0]                r_width, r_height;
    logic                      r_out_valid;
    logic [15:0]               r_out_val;

    logic [1:0]                r_op;
    logic [7:0]                r_x, r_z;
    logic [1:0]                r_ch;
    logic [16:0]               r_c, r_cu, r_cv;
    logic [8:0]                r_x0, r_z0;
    logic [15:0]               r_tx, r_tz;
    logic [AW-1:0]             r_row0, r_row1, r_addr;
    logic [7:0]                r_c00, r_c10, r_c01, r_c11;
    logic [23:0]               r_top;
    logic [15:0]               r_res;

    logic [8:0]                eff_w, eff_h;
    logic                      usable_in, in_range, accept, out_fire, load_out;
    logic                      clr_last;
    logic [9:0]                x0_inc, z0_inc;
    logic [8:0]                x1, z1;

    t_mac_op                   mac_op;
    logic signed [MAC_P_W-1:0] mac_p;

    logic [CHANNELS-1:0]       st_we;
    logic [AW-1:0]             st_addr;
    logic [CHANNELS-1:0][7:0]  st_wdata;
    logic [CHANNELS-1:0][7:0]  st_rdata;
    logic [7:0]                rd_byte;

    // Effective sizes: oversized registers act as the store side
    assign eff_w = (int'(r_width) > MAX_SIDE) ? 9'(MAX_SIDE) : r_width;
    assign eff_h = (int'(r_height) > MAX_SIDE) ? 9'(MAX_SIDE) : r_height;

    // Checks of the offered item
    assign usable_in = (eff_w != 9'd0) && (eff_h != 9'd0)
                       && (int'(i_channel_sel) < CHANNELS);
    assign in_range  = ({1'b0, i_texel_x} < eff_w) && ({1'b0, i_texel_z} < eff_h);

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);
    assign clr_last = (r_clr_addr == AW'(DEPTH - 1));

    // Clamp-to-edge right and lower neighbors
    assign x0_inc = {1'b0, r_x0} + 10'd1;
    assign z0_inc = {1'b0, r_z0} + 10'd1;
    assign x1 = (x0_inc < {1'b0, eff_w}) ? x0_inc[8:0] : eff_w - 9'd1;
    assign z1 = (z0_inc < {1'b0, eff_h}) ? z0_inc[8:0] : eff_h - 9'd1;

    // Select the requested channel from the read data
    always_comb begin
        rd_byte = 8'd0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_ch == 2'(c)) begin
                rd_byte = st_rdata[c];
            end
        end
    end

    // Sequence one item
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((i_opcode == OP_WRITE || i_opcode == OP_READ)
                        && usable_in && in_range) begin
                        n_state = ST_ADDR;
                    end else if (i_opcode == OP_SAMPLE && usable_in) begin
                        n_state = ST_PU;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_ADDR:  n_state = (r_op == OP_WRITE) ? ST_WV : ST_RD;
            ST_WV:    n_state = ST_WR;
            ST_WR:    n_state = ST_DONE;
            ST_RD:    n_state = ST_RDW;
            ST_RDW:   n_state = ST_DONE;
            ST_PU:    n_state = ST_PV;
            ST_PV:    n_state = ST_ZA;
            ST_ZA:    n_state = ST_ZB;
            ST_ZB:    n_state = ST_R00;
            ST_R00:   n_state = ST_R10;
            ST_R10:   n_state = ST_R01;
            ST_R01:   n_state = ST_R11;
            ST_R11:   n_state = ST_TOP;
            ST_TOP:   n_state = ST_BOT;
            ST_BOT:   n_state = ST_FULL;
            ST_FULL:  n_state = ST_RES;
            ST_RES:   n_state = ST_DONE;
            ST_DONE:  if (load_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Drive the shared multiply-add unit
    always_comb begin
        mac_op = '0;
        case (r_state)
            ST_ADDR: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(r_z);
                mac_op.b  = MAC_B_W'(eff_w);
                mac_op.c  = MAC_P_W'(r_x);
            end
            ST_WV: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(r_c);
                mac_op.b  = MAC_B_W'(WR_SCALE);
                mac_op.c  = MAC_P_W'(ROUND_HALF);
            end
            ST_PU: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(r_cu);
                mac_op.b  = MAC_B_W'(eff_w - 9'd1);
            end
            ST_PV: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(r_cv);
                mac_op.b  = MAC_B_W'(eff_h - 9'd1);
            end
            ST_ZA: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(mac_p[24:16]);
                mac_op.b  = MAC_B_W'(eff_w);
            end
            ST_ZB: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'(z1);
                mac_op.b  = MAC_B_W'(eff_w);
            end
            ST_TOP: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'($signed({1'b0, r_c10}) - $signed({1'b0, r_c00}));
                mac_op.b  = MAC_B_W'(r_tx);
                mac_op.c  = MAC_P_W'({r_c00, 16'h0000});
            end
            ST_BOT: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'($signed({1'b0, r_c11}) - $signed({1'b0, r_c01}));
                mac_op.b  = MAC_B_W'(r_tx);
                mac_op.c  = MAC_P_W'({r_c01, 16'h0000});
            end
            ST_FULL: begin
                mac_op.en = 1'b1;
                mac_op.a  = MAC_A_W'($signed({1'b0, mac_p[23:0]}) - $signed({1'b0, r_top}));
                mac_op.b  = MAC_B_W'(r_tz);
                mac_op.c  = MAC_P_W'({r_top, 16'h0000});
            end
            default: mac_op = '0;
        endcase
    end

    // Drive the store port
    always_comb begin
        st_we   = '0;
        st_addr = r_addr;
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_state == ST_CLEAR) begin
                st_wdata[c] = (c == ALPHA_CH) ? ALPHA_RESET : 8'h00;
            end else begin
                st_wdata[c] = mac_p[23:16];
            end
        end
        case (r_state)
            ST_CLEAR: begin
                st_we   = '1;
                st_addr = r_clr_addr;
            end
            ST_WR: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    st_we[c] = (r_ch == 2'(c));
                end
            end
            ST_RD:   st_addr = mac_p[AW-1:0];
            ST_R00:  st_addr = r_row0 + AW'(r_x0);
            ST_R10:  st_addr = r_row0 + AW'(x1);
            ST_R01:  st_addr = r_row1 + AW'(r_x0);
            ST_R11:  st_addr = r_row1 + AW'(x1);
            default: st_addr = r_addr;
        endcase
    end

    // Control state, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_width     <= SIDE_RESET;
            r_height    <= SIDE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) begin
                    r_width <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_HEIGHT) begin
                    r_height <= i_cfg_wdata;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and intermediate results
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_val <= r_res;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_op  <= i_opcode;
                    r_x   <= i_texel_x;
                    r_z   <= i_texel_z;
                    r_ch  <= i_channel_sel;
                    r_c   <= clamp_unit(i_write_value);
                    r_cu  <= clamp_unit(i_coord_u);
                    r_cv  <= clamp_unit(i_coord_v);
                    r_res <= 16'd0;
                end
            end
            ST_WV:   r_addr <= mac_p[AW-1:0];
            ST_RDW:  r_res  <= {rd_byte, 8'h00};
            ST_PV: begin
                r_x0 <= mac_p[24:16];
                r_tx <= mac_p[15:0];
            end
            ST_ZA: begin
                r_z0 <= mac_p[24:16];
                r_tz <= mac_p[15:0];
            end
            ST_ZB:   r_row0 <= mac_p[AW-1:0];
            ST_R00:  r_row1 <= mac_p[AW-1:0];
            ST_R10:  r_c00  <= rd_byte;
            ST_R01:  r_c10  <= rd_byte;
            ST_R11:  r_c01  <= rd_byte;
            ST_TOP:  r_c11  <= rd_byte;
            ST_BOT:  r_top  <= mac_p[23:0];
            ST_RES:  r_res  <= mac_p[39:24];
            default: r_res  <= r_res;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_val;

    bms_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .o_p   (mac_p)
    );

    bms_store #(
        .DEPTH (DEPTH),
        .LANES (CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_addr  (st_addr),
        .i_wdata (st_wdata),
        .o_rdata (st_rdata)
    );

endmodule

`default_nettype wire

// ----- hdl/bms_checker.sv -----
// Port-level checker of the bilinear mask sampler and its bind.
`default_nettype none

module bms_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_result_value
);

    logic [1:0] r_pend, n_pend;
    logic       in_xfer, out_xfer;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    // Count items taken whose result is not yet transferred
    always_comb begin
        n_pend = r_pend;
        if (in_xfer && !out_xfer) begin
            n_pend = r_pend + 2'd1;
        end else if (!in_xfer && out_xfer) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // One item at a time: input drops after a transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_ready)
        else $error("input ready right after a transfer");

    // A stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_value)))
        else $error("stalled result changed or dropped");

    // No result without an item behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pend != 2'd0))
        else $error("result with no pending item");

    // At most one result waits when a new item is taken
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (r_pend <= 2'd1))
        else $error("item taken while two are pending");

    // Reset empties both channels
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_ready))
        else $error("handshake active after reset");

endmodule

bind bilinear_mask_sampler bms_checker u_bms_checker (.*);

`default_nettype wire
